// ----- hw/rtl/vbq_pkg.sv -----
package vbq_pkg;

   localparam int TIME_W      = 40;
   localparam int SRC_W       = 16;
   localparam int AXIS_W      = 16;
   localparam int WIN_W       = 32;
   localparam int MODE_W      = 4;
   localparam int MODE_EN_LSB = 0;
   localparam int MODE_AB_LSB = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIGITAL_ENABLE   = 3'd0,
      CSR_AXIS_THRESHOLD_A = 3'd1,
      CSR_AXIS_THRESHOLD_B = 3'd2,
      CSR_AXIS_MODE        = 3'd3,
      CSR_PRESS_WINDOW     = 3'd4,
      CSR_RELEASE_WINDOW   = 3'd5,
      CSR_REPEAT_DELAY     = 3'd6,
      CSR_REPEAT_INTERVAL  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [SRC_W-1:0]         digital_enable;
      logic signed [AXIS_W-1:0] threshold_a;
      logic signed [AXIS_W-1:0] threshold_b;
      logic [MODE_W-1:0]        axis_mode;
   } front_cfg_type;

   typedef struct packed {
      logic [WIN_W-1:0] press_window;
      logic [WIN_W-1:0] release_window;
      logic [WIN_W-1:0] repeat_delay;
      logic [WIN_W-1:0] repeat_interval;
   } back_cfg_type;

   // classified frame as handed from front to back
   typedef struct packed {
      logic [TIME_W-1:0] now_ticks;
      logic              down;
      logic              pressed;
      logic              released;
   } event_type;

   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

endpackage

// ----- hw/rtl/vbq_front.sv -----
module vbq_front #(
   parameter int NUM_SOURCES = 16,
   parameter int NUM_AXES    = 2
) (
   input  logic                               clock,
   input  logic                               reset,
   input  vbq_pkg::front_cfg_type             cfg,
   input  logic                               take,
   input  logic [vbq_pkg::TIME_W-1:0]         now_ticks,
   input  logic [vbq_pkg::SRC_W-1:0]          source_down,
   input  logic [vbq_pkg::SRC_W-1:0]          source_pressed,
   input  logic [vbq_pkg::SRC_W-1:0]          source_released,
   input  logic signed [vbq_pkg::AXIS_W-1:0]  axis_sample_a,
   input  logic signed [vbq_pkg::AXIS_W-1:0]  axis_sample_b,
   output vbq_pkg::event_type                 entry
);
   import vbq_pkg::*;

   logic [SRC_W-1:0]         src_mask;
   logic [SRC_W-1:0]         en;
   logic signed [AXIS_W-1:0] prior_axis_ff [NUM_AXES];
   logic signed [AXIS_W-1:0] prior_axis_in [NUM_AXES];
   logic [NUM_AXES-1:0]      ax_down;
   logic [NUM_AXES-1:0]      ax_pressed;
   logic [NUM_AXES-1:0]      ax_released;

   for (genvar s = 0; s < SRC_W; s++) begin : g_mask
      assign src_mask[s] = (s < NUM_SOURCES);
   end

   assign en = cfg.digital_enable & src_mask;

   for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
      logic signed [AXIS_W-1:0] cur;
      logic signed [AXIS_W-1:0] thr;
      logic signed [AXIS_W-1:0] prev;
      logic                     on;
      logic                     above;
      logic                     d;

      assign cur   = (g == 0) ? axis_sample_a : axis_sample_b;
      assign thr   = (g == 0) ? cfg.threshold_a : cfg.threshold_b;
      assign prev  = prior_axis_ff[g];
      assign on    = cfg.axis_mode[MODE_EN_LSB + g];
      assign above = cfg.axis_mode[MODE_AB_LSB + g];

      always_comb begin
         if (above) begin
            d              = cur >= thr;
            ax_pressed[g]  = on && d && (prev < thr);
            ax_released[g] = on && !d && (prev >= thr);
         end else begin
            d              = cur <= thr;
            ax_pressed[g]  = on && d && (prev > thr);
            ax_released[g] = on && !d && (prev <= thr);
         end
         ax_down[g] = on && d;
      end

      // sample is kept every frame, enabled or not
      assign prior_axis_in[g] = take ? cur : prior_axis_ff[g];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_AXES; i++) begin
         if (reset) begin
            prior_axis_ff[i] <= '0;
         end else begin
            prior_axis_ff[i] <= prior_axis_in[i];
         end
      end
   end

   assign entry.now_ticks = now_ticks;
   assign entry.down      = |(source_down & en) || |ax_down;
   assign entry.pressed   = |(source_pressed & en) || |ax_pressed;
   assign entry.released  = |(source_released & en) || |ax_released;

endmodule

// ----- hw/rtl/vbq_queue.sv -----
module vbq_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  vbq_pkg::event_type        push_data,
   input  logic                      pop,
   output vbq_pkg::event_type        head,
   output vbq_pkg::queue_status_type status
);
   import vbq_pkg::*;

   event_type         entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.valid = (count_ff != '0);
   assign head         = entries_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && status.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hw/rtl/vbq_rem.sv -----
module vbq_rem (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [vbq_pkg::TIME_W-1:0] dividend,
   input  logic [vbq_pkg::WIN_W-1:0]  divisor,
   output logic                       done,
   output logic [vbq_pkg::WIN_W-1:0]  remainder
);
   import vbq_pkg::*;

   localparam int CNT_W = $clog2(TIME_W + 1);

   logic [TIME_W-1:0] dvd_ff, dvd_in;
   logic [WIN_W-1:0]  dvs_ff, dvs_in;
   logic [WIN_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [WIN_W:0]    shifted;

   // restoring remainder, one dividend bit per cycle
   assign shifted = {rem_ff, dvd_ff[TIME_W-1]};

   always_comb begin
      dvd_in   = dvd_ff;
      dvs_in   = dvs_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         dvd_in   = dividend;
         dvs_in   = divisor;
         rem_in   = '0;
         count_in = CNT_W'(TIME_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         dvd_in   = {dvd_ff[TIME_W-2:0], 1'b0};
         rem_in   = (shifted >= {1'b0, dvs_ff}) ? WIN_W'(shifted - {1'b0, dvs_ff})
                                               : shifted[WIN_W-1:0];
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ----- hw/rtl/vbq_back.sv -----
module vbq_back (
   input  logic                      clock,
   input  logic                      reset,
   input  vbq_pkg::back_cfg_type     cfg,
   input  vbq_pkg::queue_status_type q_status,
   input  vbq_pkg::event_type        q_head,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_is_down,
   output logic                      rsp_is_pressed,
   output logic                      rsp_is_released
);
   import vbq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_PREP,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type         state_ff, state_in;
   event_type         item_ff, item_in;
   logic [TIME_W-1:0] press_time_ff, press_time_in;
   logic              press_seen_ff, press_seen_in;
   logic [TIME_W-1:0] release_time_ff, release_time_in;
   logic              release_seen_ff, release_seen_in;
   logic [TIME_W-1:0] prior_time_ff, prior_time_in;
   logic [TIME_W:0]   start_ff, start_in;
   logic              rep_try_ff, rep_try_in;
   logic              pressed_ff, pressed_in;
   logic              released_ff, released_in;
   logic [TIME_W-1:0] diff_ff, diff_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_down_ff, rsp_down_in;
   logic              rsp_pressed_ff, rsp_pressed_in;
   logic              rsp_released_ff, rsp_released_in;

   logic              div_start;
   logic [TIME_W-1:0] div_dividend;
   logic              div_done;
   logic [WIN_W-1:0]  div_rem;

   logic              press_win;
   logic              release_win;
   logic [TIME_W:0]   now_ext;
   logic [TIME_W:0]   prior_ext;
   logic [TIME_W-1:0] now_less_start;
   logic [TIME_W-1:0] prior_less_start;
   logic [TIME_W-1:0] now_less_prior;
   logic              prior_started;

   function automatic logic [TIME_W-1:0] since_f(input logic [TIME_W-1:0] now_v,
                                                 input logic [TIME_W-1:0] then_v);
      return (now_v >= then_v) ? now_v - then_v : '0;
   endfunction

   vbq_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (cfg.repeat_interval),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign press_win   = press_seen_ff &&
                        (since_f(item_ff.now_ticks, press_time_ff) <= TIME_W'(cfg.press_window));
   assign release_win = release_seen_ff &&
                        (since_f(item_ff.now_ticks, release_time_ff) <= TIME_W'(cfg.release_window));

   assign now_ext          = {1'b0, item_ff.now_ticks};
   assign prior_ext        = {1'b0, prior_time_ff};
   assign prior_started    = prior_ext >= start_ff;
   assign now_less_start   = TIME_W'(now_ext - start_ff);
   assign prior_less_start = TIME_W'(prior_ext - start_ff);
   assign now_less_prior   = item_ff.now_ticks - prior_time_ff;

   always_comb begin
      state_in        = state_ff;
      item_in         = item_ff;
      press_time_in   = press_time_ff;
      press_seen_in   = press_seen_ff;
      release_time_in = release_time_ff;
      release_seen_in = release_seen_ff;
      prior_time_in   = prior_time_ff;
      start_in        = start_ff;
      rep_try_in      = rep_try_ff;
      pressed_in      = pressed_ff;
      released_in     = released_ff;
      diff_in         = diff_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_down_in     = rsp_down_ff;
      rsp_pressed_in  = rsp_pressed_ff;
      rsp_released_in = rsp_released_ff;
      q_pop           = 1'b0;
      div_start       = 1'b0;
      div_dividend    = prior_started ? prior_less_start : '0;

      case (state_ff)
         ST_IDLE: begin
            if (q_status.valid) begin
               q_pop    = 1'b1;
               item_in  = q_head;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            start_in    = {1'b0, press_time_ff} + (TIME_W + 1)'(cfg.repeat_delay);
            pressed_in  = item_ff.pressed || press_win;
            released_in = item_ff.released || release_win;
            rep_try_in  = !item_ff.pressed && !press_win && item_ff.down &&
                          (cfg.repeat_interval != '0);
            state_in    = ST_PREP;
         end
         ST_PREP: begin
            state_in = ST_OUT;
            // repeat fires when [prior, now] crosses a multiple of the interval
            // past start; prior before start counts from zero
            if (rep_try_ff && now_ext >= start_ff) begin
               if (!prior_started) begin
                  diff_in   = now_less_start;
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else if (item_ff.now_ticks >= prior_time_ff) begin
                  diff_in   = now_less_prior;
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               pressed_in = ({1'b0, diff_ff} + (TIME_W + 1)'(div_rem)) >=
                            (TIME_W + 1)'(cfg.repeat_interval);
               state_in   = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_down_in     = item_ff.down;
               rsp_pressed_in  = pressed_ff;
               rsp_released_in = released_ff;
               if (item_ff.pressed) begin
                  press_time_in = item_ff.now_ticks;
                  press_seen_in = 1'b1;
               end
               if (item_ff.released) begin
                  release_time_in = item_ff.now_ticks;
                  release_seen_in = 1'b1;
               end
               prior_time_in = item_ff.now_ticks;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff         <= item_in;
      start_ff        <= start_in;
      rep_try_ff      <= rep_try_in;
      pressed_ff      <= pressed_in;
      released_ff     <= released_in;
      diff_ff         <= diff_in;
      rsp_down_ff     <= rsp_down_in;
      rsp_pressed_ff  <= rsp_pressed_in;
      rsp_released_ff <= rsp_released_in;
      if (reset) begin
         state_ff        <= ST_IDLE;
         press_time_ff   <= '0;
         press_seen_ff   <= 1'b0;
         release_time_ff <= '0;
         release_seen_ff <= 1'b0;
         prior_time_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         press_time_ff   <= press_time_in;
         press_seen_ff   <= press_seen_in;
         release_time_ff <= release_time_in;
         release_seen_ff <= release_seen_in;
         prior_time_ff   <= prior_time_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_down     = rsp_down_ff;
   assign rsp_is_pressed  = rsp_pressed_ff;
   assign rsp_is_released = rsp_released_ff;

endmodule

// ----- hw/rtl/virtual_button_qualifier.sv -----
// channel   handshake               payload
// req       req_valid / req_stall   now_ticks, source_down/pressed/released, axis_sample_a/b
// rsp       rsp_valid / rsp_stall   is_down, is_pressed, is_released
// csr       csr_valid / csr_ready   csr_index, csr_wdata (ready always high)
//
// Back end takes one frame at a time: IDLE (pop), EVAL, PREP, then DIV when the autorepeat
// test runs the 40-step remainder unit, then OUT loads the result register once rsp_stall allows.
// Front classifies in the accept cycle; a 2-entry queue decouples the two halves.
// Synchronous reset clears timing state, stored axis samples, config and control registers.
// req_stall rises only when the queue is full; rsp_stall holds the result register.
module virtual_button_qualifier #(
   parameter int NUM_SOURCES = 16,
   parameter int NUM_AXES    = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [vbq_pkg::TIME_W-1:0]           req_now_ticks,
   input  logic [vbq_pkg::SRC_W-1:0]            req_source_down,
   input  logic [vbq_pkg::SRC_W-1:0]            req_source_pressed,
   input  logic [vbq_pkg::SRC_W-1:0]            req_source_released,
   input  logic signed [vbq_pkg::AXIS_W-1:0]    req_axis_sample_a,
   input  logic signed [vbq_pkg::AXIS_W-1:0]    req_axis_sample_b,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_is_down,
   output logic                                 rsp_is_pressed,
   output logic                                 rsp_is_released,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [vbq_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [vbq_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import vbq_pkg::*;

   front_cfg_type    front_cfg_ff, front_cfg_in;
   back_cfg_type     back_cfg_ff, back_cfg_in;
   event_type        front_entry;
   event_type        q_head;
   queue_status_type q_status;
   logic             q_pop;
   logic             req_take;

   assign csr_ready = 1'b1;

   always_comb begin
      front_cfg_in = front_cfg_ff;
      back_cfg_in  = back_cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_DIGITAL_ENABLE:   front_cfg_in.digital_enable = csr_wdata[SRC_W-1:0];
            CSR_AXIS_THRESHOLD_A: front_cfg_in.threshold_a    = csr_wdata[AXIS_W-1:0];
            CSR_AXIS_THRESHOLD_B: front_cfg_in.threshold_b    = csr_wdata[AXIS_W-1:0];
            CSR_AXIS_MODE:        front_cfg_in.axis_mode      = csr_wdata[MODE_W-1:0];
            CSR_PRESS_WINDOW:     back_cfg_in.press_window    = csr_wdata[WIN_W-1:0];
            CSR_RELEASE_WINDOW:   back_cfg_in.release_window  = csr_wdata[WIN_W-1:0];
            CSR_REPEAT_DELAY:     back_cfg_in.repeat_delay    = csr_wdata[WIN_W-1:0];
            CSR_REPEAT_INTERVAL:  back_cfg_in.repeat_interval = csr_wdata[WIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_cfg_ff <= '0;
         back_cfg_ff  <= '0;
      end else begin
         front_cfg_ff <= front_cfg_in;
         back_cfg_ff  <= back_cfg_in;
      end
   end

   assign req_stall = q_status.full;
   assign req_take  = req_valid && !q_status.full;

   vbq_front #(
      .NUM_SOURCES (NUM_SOURCES),
      .NUM_AXES    (NUM_AXES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (front_cfg_ff),
      .take            (req_take),
      .now_ticks       (req_now_ticks),
      .source_down     (req_source_down),
      .source_pressed  (req_source_pressed),
      .source_released (req_source_released),
      .axis_sample_a   (req_axis_sample_a),
      .axis_sample_b   (req_axis_sample_b),
      .entry           (front_entry)
   );

   vbq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_take),
      .push_data (front_entry),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   vbq_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (back_cfg_ff),
      .q_status        (q_status),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_is_down     (rsp_is_down),
      .rsp_is_pressed  (rsp_is_pressed),
      .rsp_is_released (rsp_is_released)
   );

endmodule

// ----- hw/rtl/vbq_checker.sv -----
module vbq_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_is_down,
   input logic rsp_is_pressed,
   input logic rsp_is_released
);

   // frames accepted but not yet delivered: queue, back end and result register
   logic [2:0] pending_ff, pending_in;
   logic       in_xfer;
   logic       out_xfer;

   assign in_xfer  = req_valid && !req_stall;
   assign out_xfer = rsp_valid && !rsp_stall;

   always_comb begin
      pending_in = pending_ff;
      if (in_xfer && !out_xfer) begin
         pending_in = pending_ff + 3'd1;
      end else if (out_xfer && !in_xfer) begin
         pending_in = pending_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_is_down) &&
      $stable(rsp_is_pressed) && $stable(rsp_is_released))
      else $error("stalled result changed");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("result with no frame outstanding");

   a_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd4)
      else $error("more frames outstanding than storage");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> pending_ff >= 3'd2)
      else $error("input stalled while queue has room");

endmodule

bind virtual_button_qualifier vbq_checker u_vbq_checker (.*);
